FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fbfs_pkg.sv
`default_nettype none

package fbfs_pkg;

    localparam int SIZE_W = 32;
    localparam int ID_W   = 16;
    localparam int OP_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [SIZE_W-1:0] entry_size;
        logic [ID_W-1:0]   entry_id;
        logic [SIZE_W-1:0] request_size;
    } in_word_t;

    typedef struct packed {
        logic            first_found;
        logic [ID_W-1:0] first_id;
        logic            best_found;
        logic [ID_W-1:0] best_id;
        logic            worst_found;
        logic [ID_W-1:0] worst_id;
    } out_word_t;

    // Running state of one search: the three picks so far and the sizes
    // that best and worst fit are held against.
    typedef struct packed {
        logic              first_found;
        logic [ID_W-1:0]   first_id;
        logic              best_found;
        logic [ID_W-1:0]   best_id;
        logic [SIZE_W-1:0] best_size;
        logic              worst_found;
        logic [ID_W-1:0]   worst_id;
        logic [SIZE_W-1:0] worst_size;
    } fit_t;

endpackage

`default_nettype wire

FILE: rtl/free_block_fit_search.sv
// Clear and append words give no result word, and the block stays ready for the next word.
// A query over N > 0 stored entries reads them, one entry a cycle, and then loads
// its result word; with an empty table it goes straight to loading the result word.
// The next word is taken in the cycle after the result word is loaded, which waits
// while an earlier result word is still held by the receiver.
// Synchronous active-low reset empties the table and drops any result word.
`default_nettype none

module free_block_fit_search import fbfs_pkg::*; #(
    parameter int MAX_BLOCKS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

    logic [SIZE_W-1:0] size_mem [MAX_BLOCKS];
    logic [ID_W-1:0]   id_mem   [MAX_BLOCKS];

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              pend_reg, pend_next;
    logic [SIZE_W-1:0] req_reg, req_next;
    fit_t              fit_reg, fit_next;
    logic              m_valid_reg, m_valid_next;
    out_word_t         m_data_reg, m_data_next;
    logic [SIZE_W-1:0] size_rd_reg;
    logic [ID_W-1:0]   id_rd_reg;

    logic in_acc;
    logic is_query;
    logic issue;
    logic load_out;
    logic wr_en;
    fit_t fit_upd;

    assign in_acc   = s_valid && s_ready;
    assign is_query = (s_data.opcode == OP_QUERY);

    fbfs_fit_unit u_fit (
        .cur          (fit_reg),
        .entry_size   (size_rd_reg),
        .entry_id     (id_rd_reg),
        .request_size (req_reg),
        .nxt          (fit_upd)
    );

    // Sequencer outputs.
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        issue    = (state_reg == ST_SCAN) && (rd_idx_reg < count_reg);
        load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && is_query) begin
                    state_next = (count_reg == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!issue && !pend_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Table bookkeeping and the search datapath.
    always_comb begin
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        req_next    = req_reg;
        fit_next    = fit_reg;
        wr_en       = 1'b0;
        pend_next   = issue;

        if (in_acc) begin
            unique case (s_data.opcode)
                OP_CLEAR: count_next = '0;
                OP_APPEND: begin
                    if (count_reg < CNT_MAX) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_QUERY: begin
                    rd_idx_next = '0;
                    req_next    = s_data.request_size;
                    fit_next    = '0;
                end
                default: ;
            endcase
        end

        if (issue) begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end
        if (pend_reg) begin
            fit_next = fit_upd;
        end
    end

    // Output register.
    always_comb begin
        m_data_next = m_data_reg;
        if (load_out) begin
            m_data_next.first_found = fit_reg.first_found;
            m_data_next.first_id    = fit_reg.first_id;
            m_data_next.best_found  = fit_reg.best_found;
            m_data_next.best_id     = fit_reg.best_id;
            m_data_next.worst_found = fit_reg.worst_found;
            m_data_next.worst_id    = fit_reg.worst_id;
        end

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_idx_reg  <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_idx_reg  <= rd_idx_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        fit_reg    <= fit_next;
        m_data_reg <= m_data_next;
    end

    // Entry memory: one write port for appends, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            size_mem[count_reg[IDX_W-1:0]] <= s_data.entry_size;
            id_mem[count_reg[IDX_W-1:0]]   <= s_data.entry_id;
        end
        if (issue) begin
            size_rd_reg <= size_mem[rd_idx_reg[IDX_W-1:0]];
            id_rd_reg   <= id_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fbfs_fit_unit.sv
`default_nettype none

module fbfs_fit_unit import fbfs_pkg::*; (
    input  fit_t              cur,
    input  logic [SIZE_W-1:0] entry_size,
    input  logic [ID_W-1:0]   entry_id,
    input  logic [SIZE_W-1:0] request_size,
    output fit_t              nxt
);

    logic fits;
    logic smaller;
    logic larger;

    assign fits    = (entry_size >= request_size);
    assign smaller = (entry_size < cur.best_size);
    assign larger  = (entry_size > cur.worst_size);

    // Strict compares keep the earliest entry on ties.
    always_comb begin
        nxt = cur;
        if (fits) begin
            if (!cur.first_found) begin
                nxt.first_found = 1'b1;
                nxt.first_id    = entry_id;
            end
            if (!cur.best_found || smaller) begin
                nxt.best_found = 1'b1;
                nxt.best_id    = entry_id;
                nxt.best_size  = entry_size;
            end
            if (!cur.worst_found || larger) begin
                nxt.worst_found = 1'b1;
                nxt.worst_id    = entry_id;
                nxt.worst_size  = entry_size;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fbfs_checker.sv
`default_nettype none
`include "assert_macros.svh"

module fbfs_checker import fbfs_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // A held result word must not change under backpressure.
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result word changed while stalled")

    // Any fitting entry is first, best and worst candidate alike.
    `ASSERT_IMPL(a_found_agree, aclk, aresetn, m_valid, (m_data.first_found == m_data.best_found) && (m_data.first_found == m_data.worst_found), "found flags disagree")

    // With no fit every id reads as zero.
    `ASSERT_IMPL(a_none_zero, aclk, aresetn, m_valid && !m_data.first_found, (m_data.first_id == '0) && (m_data.best_id == '0) && (m_data.worst_id == '0), "nonzero id without a fit")

    // A query occupies the block; nothing is taken in the next cycle.
    `ASSERT_NEXT(a_query_busy, aclk, aresetn, s_valid && s_ready && (s_data.opcode == OP_QUERY), !s_ready, "ready right after a query")

endmodule

bind free_block_fit_search fbfs_checker u_fbfs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
